[rtl/bpiq_pkg.sv]
// Shared constants, command and status codes, and control types of the buffer pool index queue.
package bpiq_pkg;

   localparam int NUM_BUFFERS = 16;
   localparam int IDX_W       = $clog2(NUM_BUFFERS);
   localparam int LINK_W      = IDX_W + 1;
   localparam int PTR_W       = IDX_W + 1;
   localparam int CMD_W       = 3;
   localparam int CNT_W       = 13;
   localparam int STATUS_W    = 2;
   localparam int TOTAL_W     = 32;

   localparam logic [CNT_W-1:0] MAX_BYTES = CNT_W'(4096);

   localparam logic [CMD_W-1:0] CMD_ALLOCATE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_COMMIT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUBLISH  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELIVER  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd3;

   typedef struct packed {
      logic load;
      logic fetch;
      logic exec;
   } bpiq_cmd_type;

   typedef struct packed {
      logic req_deliver;
      logic rsp_busy;
   } bpiq_status_type;

   function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] n);
      return (n > MAX_BYTES) ? MAX_BYTES : n;
   endfunction

endpackage

[rtl/bpiq_if.sv]
// Request and response channel interfaces of the buffer pool index queue.
interface bpiq_req_if import bpiq_pkg::*;;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [IDX_W-1:0]    buffer_index;
   logic [CNT_W-1:0]    byte_count;

   modport source (output valid, output cmd, output buffer_index, output byte_count,
                   input ready);
   modport sink (input valid, input cmd, input buffer_index, input byte_count,
                 output ready);
endinterface

interface bpiq_rsp_if import bpiq_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    out_index;
   logic [CNT_W-1:0]    out_length;
   logic [TOTAL_W-1:0]  publish_ok_total;
   logic [TOTAL_W-1:0]  publish_fail_total;
   logic [TOTAL_W-1:0]  delivered_total;

   modport source (output valid, output status, output out_index, output out_length,
                   output publish_ok_total, output publish_fail_total,
                   output delivered_total, input ready);
   modport sink (input valid, input status, input out_index, input out_length,
                 input publish_ok_total, input publish_fail_total,
                 input delivered_total, output ready);
endinterface

[rtl/bpiq_ctrl.sv]
// Control state machine that sequences load, the second read of a deliver, and execute of each command.
module bpiq_ctrl import bpiq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  bpiq_status_type dp_status,
   output bpiq_cmd_type    ctrl_cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_ready      = ready_ff;
   assign ctrl_cmd.load  = req_valid & ready_ff;
   assign ctrl_cmd.fetch = (state_ff == S_FETCH);
   assign ctrl_cmd.exec  = (state_ff == S_EXEC) & ~dp_status.rsp_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (ctrl_cmd.load) begin
                  state_ff <= dp_status.req_deliver ? S_FETCH : S_EXEC;
                  ready_ff <= 1'b0;
               end
            end
            S_FETCH: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (!dp_status.rsp_busy) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (state_ff == S_IDLE))
      else $error("request ready outside the idle state");

   a_deliver_fetches: assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.load && dp_status.req_deliver) |=> ctrl_cmd.fetch)
      else $error("deliver transfer did not take the second read");

   a_fetch_then_exec: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.fetch |=> (state_ff == S_EXEC))
      else $error("second read not followed by execute");
`endif

endmodule

[rtl/bpiq_datapath.sv]
// Datapath holding the free list, committed lengths, index ring, counters and response register.
module bpiq_datapath import bpiq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  bpiq_cmd_type        ctrl_cmd,
   output bpiq_status_type     dp_status,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [IDX_W-1:0]    req_buffer_index,
   input  logic [CNT_W-1:0]    req_byte_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_out_index,
   output logic [CNT_W-1:0]    rsp_out_length,
   output logic [TOTAL_W-1:0]  rsp_publish_ok_total,
   output logic [TOTAL_W-1:0]  rsp_publish_fail_total,
   output logic [TOTAL_W-1:0]  rsp_delivered_total
);

   logic [LINK_W-1:0]   free_next_ff [NUM_BUFFERS];
   logic [CNT_W-1:0]    committed_len_ff [NUM_BUFFERS];
   logic [IDX_W-1:0]    fifo_slots_ff [NUM_BUFFERS];

   logic [CMD_W-1:0]    cmd_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [LINK_W-1:0]   link_rd_ff;
   logic [CNT_W-1:0]    len_rd_ff;
   logic [IDX_W-1:0]    slot_rd_ff;

   logic [LINK_W-1:0]   free_head_ff, free_head_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [TOTAL_W-1:0]  ok_total_ff, ok_total_in;
   logic [TOTAL_W-1:0]  fail_total_ff, fail_total_in;
   logic [TOTAL_W-1:0]  dlv_total_ff, dlv_total_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    out_index_ff, out_index_in;
   logic [CNT_W-1:0]    out_length_ff, out_length_in;

   logic                link_we;
   logic [IDX_W-1:0]    link_waddr;
   logic                len_we;
   logic [IDX_W-1:0]    len_waddr;
   logic [CNT_W-1:0]    len_wdata;
   logic                slot_we;

   logic [PTR_W-1:0]    fifo_fill;
   logic                fifo_full;
   logic                fifo_empty;
   logic                idx_ok;

   assign fifo_fill  = wr_ptr_ff - rd_ptr_ff;
   assign fifo_full  = (fifo_fill >= PTR_W'(NUM_BUFFERS));
   assign fifo_empty = (wr_ptr_ff == rd_ptr_ff);
   assign idx_ok     = (LINK_W'(idx_ff) < LINK_W'(NUM_BUFFERS));

   assign dp_status.req_deliver = (req_cmd == CMD_DELIVER);
   assign dp_status.rsp_busy    = rsp_valid_ff & ~rsp_ready;

   always_comb begin
      free_head_in  = free_head_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      ok_total_in   = ok_total_ff;
      fail_total_in = fail_total_ff;
      dlv_total_in  = dlv_total_ff;
      link_we       = 1'b0;
      link_waddr    = idx_ff;
      len_we        = 1'b0;
      len_waddr     = idx_ff;
      len_wdata     = clamp_len(cnt_ff);
      slot_we       = 1'b0;
      status_in     = STATUS_OK;
      out_index_in  = '0;
      out_length_in = '0;
      case (cmd_ff)
         CMD_ALLOCATE: begin
            if (free_head_ff >= LINK_W'(NUM_BUFFERS)) begin
               status_in = STATUS_NONE;
            end else begin
               out_index_in = free_head_ff[IDX_W-1:0];
               free_head_in = link_rd_ff;
               len_we       = 1'b1;
               len_waddr    = free_head_ff[IDX_W-1:0];
               len_wdata    = '0;
            end
         end
         CMD_COMMIT: begin
            if (!idx_ok) begin
               status_in = STATUS_BAD_INDEX;
            end else begin
               len_we = 1'b1;
            end
         end
         CMD_RELEASE: begin
            if (!idx_ok) begin
               status_in = STATUS_BAD_INDEX;
            end else begin
               link_we      = 1'b1;
               free_head_in = LINK_W'(idx_ff);
            end
         end
         CMD_PUBLISH: begin
            if (!idx_ok) begin
               status_in = STATUS_BAD_INDEX;
            end else begin
               len_we = (len_rd_ff == '0);
               if (fifo_full) begin
                  link_we       = 1'b1;
                  free_head_in  = LINK_W'(idx_ff);
                  fail_total_in = fail_total_ff + 1'b1;
                  status_in     = STATUS_FULL;
               end else begin
                  slot_we     = 1'b1;
                  wr_ptr_in   = wr_ptr_ff + 1'b1;
                  ok_total_in = ok_total_ff + 1'b1;
               end
            end
         end
         CMD_DELIVER: begin
            if (fifo_empty) begin
               status_in = STATUS_NONE;
            end else begin
               rd_ptr_in     = rd_ptr_ff + 1'b1;
               out_index_in  = slot_rd_ff;
               out_length_in = len_rd_ff;
               dlv_total_in  = dlv_total_ff + 1'b1;
               link_we       = 1'b1;
               link_waddr    = slot_rd_ff;
               free_head_in  = LINK_W'(slot_rd_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         ok_total_ff   <= '0;
         fail_total_ff <= '0;
         dlv_total_ff  <= '0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            free_next_ff[i]     <= LINK_W'(i + 1);
            committed_len_ff[i] <= '0;
         end
      end else if (ctrl_cmd.exec) begin
         free_head_ff  <= free_head_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         ok_total_ff   <= ok_total_in;
         fail_total_ff <= fail_total_in;
         dlv_total_ff  <= dlv_total_in;
         if (link_we) begin
            free_next_ff[link_waddr] <= free_head_ff;
         end
         if (len_we) begin
            committed_len_ff[len_waddr] <= len_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.exec && slot_we) begin
         fifo_slots_ff[wr_ptr_ff[IDX_W-1:0]] <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff     <= req_cmd;
         idx_ff     <= req_buffer_index;
         cnt_ff     <= req_byte_count;
         link_rd_ff <= free_next_ff[free_head_ff[IDX_W-1:0]];
         len_rd_ff  <= committed_len_ff[req_buffer_index];
         slot_rd_ff <= fifo_slots_ff[rd_ptr_ff[IDX_W-1:0]];
      end else if (ctrl_cmd.fetch) begin
         len_rd_ff <= committed_len_ff[slot_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.exec) begin
         status_ff     <= status_in;
         out_index_ff  <= out_index_in;
         out_length_ff <= out_length_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_out_index          = out_index_ff;
   assign rsp_out_length         = out_length_ff;
   assign rsp_publish_ok_total   = ok_total_ff;
   assign rsp_publish_fail_total = fail_total_ff;
   assign rsp_delivered_total    = dlv_total_ff;

`ifndef NO_ASSERTIONS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fifo_fill <= PTR_W'(NUM_BUFFERS))
      else $error("index ring holds more entries than buffers");

   a_head_bounded: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= LINK_W'(NUM_BUFFERS))
      else $error("free list head beyond the null link");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl_cmd.exec))
      else $error("response raised without an executed command");
`endif

endmodule

[rtl/buffer_pool_index_queue_unit.sv]
// Top level of the buffer pool index queue: free list buffer manager with an index ring.
//
//   channel  direction  payload
//   req_ch   in         cmd, buffer_index, byte_count
//   rsp_ch   out        status, out_index, out_length, three wrapping totals
//
// A request transfer registers the operands; the execute state then registers the result. A deliver
// passes through a fetch state in between, since the committed length is then read from the
// address that the ring returns. Ready comes back with the result.
// Each command reads its operands from registered-read storage and writes back in its execute
// state. Reset is synchronous and restores the free list and lengths at once.
// A new request is taken while the previous result waits; a stalled response holds execute.
module buffer_pool_index_queue_unit import bpiq_pkg::*; (
   input logic        clock,
   input logic        reset,
   bpiq_req_if.sink   req_ch,
   bpiq_rsp_if.source rsp_ch
);

   bpiq_cmd_type    ctrl_cmd;
   bpiq_status_type dp_status;

   bpiq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   bpiq_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .ctrl_cmd               (ctrl_cmd),
      .dp_status              (dp_status),
      .req_cmd                (req_ch.cmd),
      .req_buffer_index       (req_ch.buffer_index),
      .req_byte_count         (req_ch.byte_count),
      .rsp_valid              (rsp_ch.valid),
      .rsp_ready              (rsp_ch.ready),
      .rsp_status             (rsp_ch.status),
      .rsp_out_index          (rsp_ch.out_index),
      .rsp_out_length         (rsp_ch.out_length),
      .rsp_publish_ok_total   (rsp_ch.publish_ok_total),
      .rsp_publish_fail_total (rsp_ch.publish_fail_total),
      .rsp_delivered_total    (rsp_ch.delivered_total)
   );

endmodule

[tb/bpiq_tb_pkg.sv]
// Scoreboard class and reply type for the buffer pool index queue testbench.
`timescale 1ns / 100ps
package bpiq_tb_pkg;
   import bpiq_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_DELIVER + 1'b1;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    out_index;
      logic [CNT_W-1:0]    out_length;
      logic [TOTAL_W-1:0]  ok_total;
      logic [TOTAL_W-1:0]  fail_total;
      logic [TOTAL_W-1:0]  delivered_total;
   } bpiq_reply_type;

   class bpiq_scoreboard;
      logic [LINK_W-1:0]  free_link [NUM_BUFFERS];
      logic [LINK_W-1:0]  free_head;
      logic [CNT_W-1:0]   buffer_length [NUM_BUFFERS];
      logic [IDX_W-1:0]   ring_slot [NUM_BUFFERS];
      logic [PTR_W-1:0]   ring_wr_ptr;
      logic [PTR_W-1:0]   ring_rd_ptr;
      logic [TOTAL_W-1:0] ok_count;
      logic [TOTAL_W-1:0] fail_count;
      logic [TOTAL_W-1:0] delivered_count;
      bpiq_reply_type     pending_replies [$];
      int unsigned        mismatch_count;

      function new();
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            free_link[i]     = LINK_W'(i + 1);
            buffer_length[i] = '0;
            ring_slot[i]     = '0;
         end
         free_head       = '0;
         ring_wr_ptr     = '0;
         ring_rd_ptr     = '0;
         ok_count        = '0;
         fail_count      = '0;
         delivered_count = '0;
         mismatch_count  = 0;
      endfunction

      function logic [PTR_W-1:0] ring_fill();
         return ring_wr_ptr - ring_rd_ptr;
      endfunction

      function bit pool_empty();
         return free_head >= LINK_W'(NUM_BUFFERS);
      endfunction

      function logic [CNT_W-1:0] limit_length(logic [CNT_W-1:0] n);
         return (n > MAX_BYTES) ? MAX_BYTES : n;
      endfunction

      function void return_buffer(logic [IDX_W-1:0] idx);
         free_link[idx] = free_head;
         free_head      = {1'b0, idx};
      endfunction

      function bpiq_reply_type note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                            logic [CNT_W-1:0] cnt);
         bpiq_reply_type   r;
         logic [IDX_W-1:0] slot;
         r = '0;
         case (cmd)
            CMD_ALLOCATE: begin
               if (pool_empty()) begin
                  r.status = STATUS_NONE;
               end else begin
                  slot                = free_head[IDX_W-1:0];
                  r.out_index         = slot;
                  free_head           = free_link[slot];
                  buffer_length[slot] = '0;
               end
            end
            CMD_COMMIT: begin
               buffer_length[idx] = limit_length(cnt);
            end
            CMD_PUBLISH: begin
               if (buffer_length[idx] == '0)
                  buffer_length[idx] = limit_length(cnt);
               if (ring_fill() >= PTR_W'(NUM_BUFFERS)) begin
                  return_buffer(idx);
                  fail_count++;
                  r.status = STATUS_FULL;
               end else begin
                  ring_slot[ring_wr_ptr[IDX_W-1:0]] = idx;
                  ring_wr_ptr++;
                  ok_count++;
               end
            end
            CMD_RELEASE: begin
               return_buffer(idx);
            end
            CMD_DELIVER: begin
               if (ring_fill() == '0) begin
                  r.status = STATUS_NONE;
               end else begin
                  slot         = ring_slot[ring_rd_ptr[IDX_W-1:0]];
                  ring_rd_ptr++;
                  r.out_index  = slot;
                  r.out_length = buffer_length[slot];
                  delivered_count++;
                  return_buffer(slot);
               end
            end
            default: begin
            end
         endcase
         r.ok_total        = ok_count;
         r.fail_total      = fail_count;
         r.delivered_total = delivered_count;
         pending_replies.insert(pending_replies.size(), r);
         return r;
      endfunction

      task report_mismatch(string field, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
         if (mismatch_count < 100)
            $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", field, want, got, $time);
         mismatch_count++;
      endtask

      task check_reply(bpiq_reply_type got);
         bpiq_reply_type want;
         if (pending_replies.size() == 0) begin
            report_mismatch("reply with nothing pending", '0, got.status);
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", want.status, got.status);
            if (got.out_index !== want.out_index)
               report_mismatch("out_index", want.out_index, got.out_index);
            if (got.out_length !== want.out_length)
               report_mismatch("out_length", want.out_length, got.out_length);
            if (got.ok_total !== want.ok_total)
               report_mismatch("publish_ok_total", want.ok_total, got.ok_total);
            if (got.fail_total !== want.fail_total)
               report_mismatch("publish_fail_total", want.fail_total, got.fail_total);
            if (got.delivered_total !== want.delivered_total)
               report_mismatch("delivered_total", want.delivered_total, got.delivered_total);
         end
      endtask
   endclass

endpackage

[tb/tb_buffer_pool_index_queue_unit.sv]
// Top level testbench of the buffer pool index queue with stimulus and reply checking.
`timescale 1ns / 100ps
module tb_buffer_pool_index_queue_unit;
   import bpiq_pkg::*;
   import bpiq_tb_pkg::*;

   localparam int WELL_FORMED_ITEMS = 650;
   localparam int TOTAL_ITEMS       = 820;

   logic             clock = 1'b0;
   logic             reset;
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;
   int unsigned      items_sent;
   bpiq_scoreboard   sb;
   logic [IDX_W-1:0] held_buffers [$];

   bpiq_req_if req_ch ();
   bpiq_rsp_if rsp_ch ();

   buffer_pool_index_queue_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_reply({rsp_ch.status, rsp_ch.out_index, rsp_ch.out_length,
                         rsp_ch.publish_ok_total, rsp_ch.publish_fail_total,
                         rsp_ch.delivered_total});
      rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic [CNT_W-1:0] cnt, output bpiq_reply_type reply);
      if (items_sent < TOTAL_ITEMS / 3) begin
         send_idle_pct = 17;
         recv_idle_pct = 66;
      end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
         send_idle_pct = 66;
         recv_idle_pct = 17;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.buffer_index <= idx;
      req_ch.byte_count   <= cnt;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      reply = sb.note_command(cmd, idx, cnt);
      items_sent++;
      if (cmd == CMD_ALLOCATE && reply.status == STATUS_OK)
         held_buffers.insert(held_buffers.size(), reply.out_index);
   endtask

   function automatic logic [CNT_W-1:0] pick_length();
      case ($urandom_range(5, 0))
         0: return '0;
         1: return CNT_W'($urandom_range(16, 1));
         2: return MAX_BYTES - CNT_W'($urandom_range(1, 0));
         3: return MAX_BYTES + CNT_W'($urandom_range(1, 0));
         4: return '1;
         default: return CNT_W'($urandom);
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] take_held(bit remove);
      int unsigned      pos;
      logic [IDX_W-1:0] idx;
      if (held_buffers.size() == 0)
         return IDX_W'($urandom);
      pos = $urandom_range(held_buffers.size() - 1, 0);
      idx = held_buffers[pos];
      if (remove)
         held_buffers.delete(pos);
      return idx;
   endfunction

   initial begin
      bpiq_reply_type   reply;
      logic [IDX_W-1:0] slot;
      int unsigned      guard;
      sb = new();
      items_sent    = 0;
      send_idle_pct = 17;
      recv_idle_pct = 66;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.cmd          <= CMD_ALLOCATE;
      req_ch.buffer_index <= '0;
      req_ch.byte_count   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_command(CMD_DELIVER, '0, '0, reply);
      send_command(CMD_SPARE_FIRST, '1, '1, reply);
      send_command(CMD_SPARE_FIRST + 1'b1, 4'd5, 13'd77, reply);
      send_command(CMD_SPARE_LAST, '0, '1, reply);
      send_command(CMD_ALLOCATE, '1, '1, reply);
      slot = reply.out_index;
      send_command(CMD_COMMIT, slot, '1, reply);
      send_command(CMD_PUBLISH, slot, 13'd5, reply);
      send_command(CMD_ALLOCATE, '0, '0, reply);
      send_command(CMD_PUBLISH, reply.out_index, MAX_BYTES + 1'b1, reply);
      send_command(CMD_ALLOCATE, '0, '0, reply);
      slot = reply.out_index;
      send_command(CMD_COMMIT, slot, '0, reply);
      send_command(CMD_PUBLISH, slot, '0, reply);
      send_command(CMD_ALLOCATE, '0, '0, reply);
      slot = reply.out_index;
      send_command(CMD_COMMIT, slot, MAX_BYTES - 1'b1, reply);
      send_command(CMD_RELEASE, slot, '0, reply);
      repeat (4) send_command(CMD_DELIVER, '0, '0, reply);
      send_command(CMD_ALLOCATE, '0, '0, reply);
      send_command(CMD_PUBLISH, reply.out_index, 13'd1, reply);
      held_buffers.delete();

      while (items_sent < WELL_FORMED_ITEMS) begin
         guard = 0;
         case ($urandom_range(99, 0)) inside
            [0:7]: begin
               while (!sb.pool_empty() && guard < 20) begin
                  send_command(CMD_ALLOCATE, IDX_W'($urandom), pick_length(), reply);
                  guard++;
               end
               send_command(CMD_ALLOCATE, IDX_W'($urandom), pick_length(), reply);
            end
            [8:15]: begin
               while (sb.ring_fill() != '0 && guard < 20) begin
                  send_command(CMD_DELIVER, IDX_W'($urandom), pick_length(), reply);
                  guard++;
               end
               send_command(CMD_DELIVER, IDX_W'($urandom), pick_length(), reply);
            end
            [16:23]: begin
               while ((held_buffers.size() != 0 || !sb.pool_empty()) && guard < 40) begin
                  if (held_buffers.size() == 0)
                     send_command(CMD_ALLOCATE, IDX_W'($urandom), pick_length(), reply);
                  else
                     send_command(CMD_PUBLISH, take_held(1'b1), pick_length(), reply);
                  guard++;
               end
            end
            [24:31]: begin
               case ($urandom_range(3, 0))
                  0: send_command(CMD_SPARE_FIRST + CMD_W'($urandom_range(2, 0)),
                                  IDX_W'($urandom), CNT_W'($urandom), reply);
                  1: send_command(CMD_COMMIT, IDX_W'($urandom), pick_length(), reply);
                  2: send_command(CMD_DELIVER, IDX_W'($urandom), CNT_W'($urandom), reply);
                  default: send_command(CMD_ALLOCATE, IDX_W'($urandom), CNT_W'($urandom),
                                        reply);
               endcase
            end
            default: begin
               case ($urandom_range(4, 0))
                  0: send_command(CMD_ALLOCATE, IDX_W'($urandom), pick_length(), reply);
                  1: send_command(CMD_COMMIT, take_held(1'b0), pick_length(), reply);
                  2: begin
                     if (held_buffers.size() == 0)
                        send_command(CMD_ALLOCATE, IDX_W'($urandom), pick_length(), reply);
                     else
                        send_command(CMD_PUBLISH, take_held(1'b1), pick_length(), reply);
                  end
                  3: send_command(CMD_DELIVER, IDX_W'($urandom), pick_length(), reply);
                  default: begin
                     if (held_buffers.size() != 0)
                        send_command(CMD_RELEASE, take_held(1'b1), pick_length(), reply);
                  end
               endcase
            end
         endcase
      end

      // Releasing or publishing buffers that are not held corrupts the free list for good,
      // so this misuse and the full queue it enables come last.
      while (items_sent < TOTAL_ITEMS) begin
         guard = 0;
         case ($urandom_range(99, 0)) inside
            [0:19]: begin
               while (sb.ring_fill() < PTR_W'(NUM_BUFFERS) && guard < 20) begin
                  send_command(CMD_PUBLISH, IDX_W'($urandom), pick_length(), reply);
                  guard++;
               end
               repeat ($urandom_range(3, 1))
                  send_command(CMD_PUBLISH, IDX_W'($urandom), pick_length(), reply);
            end
            [20:39]: begin
               while (sb.ring_fill() != '0 && guard < 20) begin
                  send_command(CMD_DELIVER, IDX_W'($urandom), pick_length(), reply);
                  guard++;
               end
               send_command(CMD_DELIVER, IDX_W'($urandom), pick_length(), reply);
            end
            [40:54]: send_command(CMD_RELEASE, IDX_W'($urandom), pick_length(), reply);
            [55:69]: send_command(CMD_PUBLISH, IDX_W'($urandom), pick_length(), reply);
            default: begin
               case ($urandom_range(2, 0))
                  0: send_command(CMD_ALLOCATE, IDX_W'($urandom), pick_length(), reply);
                  1: send_command(CMD_DELIVER, IDX_W'($urandom), pick_length(), reply);
                  default: send_command(CMD_COMMIT, IDX_W'($urandom), pick_length(), reply);
               endcase
            end
         endcase
      end

      req_ch.valid <= 1'b0;
      while (sb.pending_replies.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
